// ===== rtl/pdcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pdcc_pkg;

   localparam int COORD_W = 16;
   localparam int DIST_W  = 36;
   localparam int INV_W   = 24;
   localparam int CNT_W   = 13;
   localparam int IDX_W   = 12;

   typedef enum logic [1:0] {
      ST_ACCEPTED = 2'd0,
      ST_TOO_CLOSE = 2'd1,
      ST_OUTSIDE = 2'd2,
      ST_TARGET = 2'd3
   } status_type;

   localparam logic [2:0] REG_MIN_DIST = 3'd0;
   localparam logic [2:0] REG_INV_CELL = 3'd1;
   localparam logic [2:0] REG_LOWER_X  = 3'd2;
   localparam logic [2:0] REG_LOWER_Y  = 3'd3;
   localparam logic [2:0] REG_LOWER_Z  = 3'd4;
   localparam logic [2:0] REG_TARGET   = 3'd5;

   // configuration seen by the datapath
   typedef struct packed {
      logic [DIST_W-1:0]  min_dist_sq;
      logic [INV_W-1:0]   inv_cell_size;
      logic [COORD_W-1:0] lower_x;
      logic [COORD_W-1:0] lower_y;
      logic [COORD_W-1:0] lower_z;
      logic [CNT_W-1:0]   target_count;
   } cfg_type;

endpackage
`default_nettype wire

// ===== rtl/pdcc_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pdcc_regs
   import pdcc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [5:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic      [63:0] prdata,
   output logic             pready,
   output cfg_type          cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] sel;

   assign pready = 1'b1;
   assign sel    = paddr[5:3];
   assign cfg    = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (sel)
            REG_MIN_DIST: cfg_in.min_dist_sq   = pwdata[DIST_W-1:0];
            REG_INV_CELL: cfg_in.inv_cell_size = pwdata[INV_W-1:0];
            REG_LOWER_X:  cfg_in.lower_x       = pwdata[COORD_W-1:0];
            REG_LOWER_Y:  cfg_in.lower_y       = pwdata[COORD_W-1:0];
            REG_LOWER_Z:  cfg_in.lower_z       = pwdata[COORD_W-1:0];
            REG_TARGET:   cfg_in.target_count  = pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_dist_sq   <= '0;
         cfg_ff.inv_cell_size <= INV_W'(65536);
         cfg_ff.lower_x       <= '0;
         cfg_ff.lower_y       <= '0;
         cfg_ff.lower_z       <= '0;
         cfg_ff.target_count  <= CNT_W'(4096);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      prdata = '0;
      case (sel)
         REG_MIN_DIST: prdata = 64'(cfg_ff.min_dist_sq);
         REG_INV_CELL: prdata = 64'(cfg_ff.inv_cell_size);
         REG_LOWER_X:  prdata = 64'(cfg_ff.lower_x);
         REG_LOWER_Y:  prdata = 64'(cfg_ff.lower_y);
         REG_LOWER_Z:  prdata = 64'(cfg_ff.lower_z);
         REG_TARGET:   prdata = 64'(cfg_ff.target_count);
         default:      prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/pdcc_dist_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Shared subtract/square/accumulate unit: one axis per cycle while en is high.
module pdcc_dist_unit
   import pdcc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               clear,
   input  wire logic               en,
   input  wire logic [COORD_W-1:0] a,
   input  wire logic [COORD_W-1:0] b,
   output logic      [DIST_W-1:0]  acc
);

   logic [DIST_W-1:0]    acc_ff, acc_in;
   logic [COORD_W-1:0]   diff;
   logic [2*COORD_W-1:0] sq;

   assign diff = (a >= b) ? (a - b) : (b - a);
   // full-width square of the axis gap
   assign sq   = diff * diff;

   always_comb begin
      acc_in = acc_ff;
      if (clear)
         acc_in = '0;
      else if (en)
         acc_in = acc_ff + DIST_W'(sq);
   end

   always_ff @(posedge clock) acc_ff <= acc_in;

   assign acc = acc_ff;

endmodule
`default_nettype wire

// ===== rtl/poisson_disk_candidate_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Poisson-disk candidate check, 3-D. Each request carries one Q8.8 point; the
// block maps it to a grid cell (one multiply per axis through a shared unit),
// then steps through the (2R+1)^3 neighbouring offsets. An offset outside the
// grid is skipped in the address step; an in-grid cell takes an address step,
// a read through the read port of the cell memory, three axis squares
// accumulated by the shared distance unit and a compare. The request channel
// is not ready while a candidate is checked, nor while a result waits. After
// reset a clearing pass over all GRID_X*GRID_Y*GRID_Z cells marks every cell
// empty before the first request is taken.
module poisson_disk_candidate_check
   import pdcc_pkg::*;
#(
   parameter int GRID_X = 16,
   parameter int GRID_Y = 16,
   parameter int GRID_Z = 16,
   parameter int SEARCH_RADIUS = 2
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // cand_x, cand_y, cand_z
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // status[1:0], point_index[13:2], done_res[14], 0
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [5:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output logic [63:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int GW    = 9;   // holds grid index up to 511, unsigned
   localparam int SW    = 4;   // offset counter, signed, -8..7
   localparam int ENTRY_W = 1 + 3 * COORD_W;

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_MAP   = 9'b000000100,
      S_CHECK = 9'b000001000,
      S_ADDR  = 9'b000010000,
      S_READ  = 9'b000100000,
      S_DIST  = 9'b001000000,
      S_WRITE = 9'b010000000,
      S_RESP  = 9'b100000000
   } state_type;

   cfg_type cfg;

   pdcc_regs u_regs (
      .clock, .reset,
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready), .cfg
   );

   state_type state_ff, state_in;
   logic [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [GW-1:0]  gx_ff, gx_in, gy_ff, gy_in, gz_ff, gz_in;
   logic signed [SW-1:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic [1:0] ax_ff, ax_in;
   logic       own_ff, own_in;
   logic       oob_ff, oob_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]  st_ff, st_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   logic        done_ff, done_in;
   logic [AW-1:0] raddr_ff, raddr_in;

   // memory
   logic [ENTRY_W-1:0] mem [CELLS];
   logic [ENTRY_W-1:0] rd_ff;
   logic               we;
   logic [AW-1:0]      waddr;
   logic [ENTRY_W-1:0] wdata;
   logic               re;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rd_ff <= mem[raddr_ff];
   end

   // shared mapping multiplier, one axis per cycle
   logic [COORD_W-1:0] map_c, map_lo;
   logic [COORD_W-1:0] map_d;
   logic [COORD_W+INV_W-1:0] map_p;
   logic [GW-1:0] map_g;
   logic          map_bad;
   logic [GW-1:0] map_lim;

   always_comb begin
      case (ax_ff)
         2'd0: begin map_c = cx_ff; map_lo = cfg.lower_x; map_lim = GW'(GRID_X); end
         2'd1: begin map_c = cy_ff; map_lo = cfg.lower_y; map_lim = GW'(GRID_Y); end
         default: begin map_c = cz_ff; map_lo = cfg.lower_z; map_lim = GW'(GRID_Z); end
      endcase
      map_d = map_c - map_lo;
      map_p = map_d * cfg.inv_cell_size;
      map_g = GW'(map_p[COORD_W+INV_W-1:24]);
      map_bad = (map_c < map_lo) || (map_p[COORD_W+INV_W-1:24] >= 16'(map_lim));
   end

   // neighbour coordinates
   logic signed [GW+1:0] nx, ny, nz;
   logic nx_ok, ny_ok, nz_ok;
   logic [AW-1:0] naddr, own_addr;
   assign nx = $signed({2'b0, gx_ff}) + (GW+2)'(ox_ff);
   assign ny = $signed({2'b0, gy_ff}) + (GW+2)'(oy_ff);
   assign nz = $signed({2'b0, gz_ff}) + (GW+2)'(oz_ff);
   assign nx_ok = (nx >= 0) && (nx < (GW+2)'(GRID_X));
   assign ny_ok = (ny >= 0) && (ny < (GW+2)'(GRID_Y));
   assign nz_ok = (nz >= 0) && (nz < (GW+2)'(GRID_Z));
   assign naddr = AW'((32'(nz[GW-1:0]) * GRID_Y + 32'(ny[GW-1:0])) * GRID_X
                      + 32'(nx[GW-1:0]));
   assign own_addr = AW'((32'(gz_ff) * GRID_Y + 32'(gy_ff)) * GRID_X + 32'(gx_ff));

   // distance unit
   logic [COORD_W-1:0] du_a, du_b;
   logic [DIST_W-1:0]  du_acc;
   logic du_clr, du_en;
   always_comb begin
      case (ax_ff)
         2'd0: begin du_a = rd_ff[COORD_W-1:0]; du_b = cx_ff; end
         2'd1: begin du_a = rd_ff[2*COORD_W-1:COORD_W]; du_b = cy_ff; end
         default: begin du_a = rd_ff[3*COORD_W-1:2*COORD_W]; du_b = cz_ff; end
      endcase
   end
   pdcc_dist_unit u_dist (
      .clock, .clear(du_clr), .en(du_en), .a(du_a), .b(du_b), .acc(du_acc)
   );

   localparam logic signed [SW-1:0] OMIN = -SW'(SEARCH_RADIUS);
   localparam logic signed [SW-1:0] OMAX = SW'(SEARCH_RADIUS);

   logic [CNT_W-1:0] cnt_next;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      gx_in = gx_ff; gy_in = gy_ff; gz_in = gz_ff;
      ox_in = ox_ff; oy_in = oy_ff; oz_in = oz_ff;
      ax_in = ax_ff; own_in = own_ff; oob_in = oob_ff;
      clr_in = clr_ff; cnt_in = cnt_ff;
      st_in = st_ff; pidx_in = pidx_ff; done_in = done_ff;
      raddr_in = raddr_ff;
      we = 1'b0; waddr = clr_ff; wdata = '0; re = 1'b0;
      du_clr = 1'b0; du_en = 1'b0;
      cnt_next = cnt_ff;
      case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (32'(clr_ff) == CELLS - 1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cx_in = req_tdata[15:0]; cy_in = req_tdata[31:16]; cz_in = req_tdata[47:32];
               ax_in = 2'd0; oob_in = 1'b0; pidx_in = '0;
               if (cnt_ff >= cfg.target_count) begin
                  st_in = ST_TARGET; done_in = 1'b1; state_in = S_RESP;
               end else begin
                  state_in = S_MAP;
               end
            end
         end
         S_MAP: begin
            if (map_bad) oob_in = 1'b1;
            case (ax_ff)
               2'd0: gx_in = map_g;
               2'd1: gy_in = map_g;
               default: gz_in = map_g;
            endcase
            if (ax_ff == 2'd2) begin
               ax_in = 2'd0;
               state_in = S_CHECK;
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end
         S_CHECK: begin
            if (oob_ff) begin
               st_in = ST_OUTSIDE; done_in = (cnt_ff >= cfg.target_count);
               state_in = S_RESP;
            end else begin
               raddr_in = own_addr; re = 1'b0;
               own_in = 1'b1;
               ox_in = OMIN; oy_in = OMIN; oz_in = OMIN;
               st_in = ST_ACCEPTED;
               state_in = S_READ;
            end
         end
         S_ADDR: begin
            // step to next in-grid neighbour, or finish
            if (nx_ok && ny_ok && nz_ok) begin
               raddr_in = naddr;
               state_in = S_READ;
            end
            if (ox_ff == OMAX) begin
               ox_in = OMIN;
               if (oy_ff == OMAX) begin
                  oy_in = OMIN;
                  oz_in = oz_ff + SW'(1);
               end else begin
                  oy_in = oy_ff + SW'(1);
               end
            end else begin
               ox_in = ox_ff + SW'(1);
            end
            if (!(nx_ok && ny_ok && nz_ok) && ox_ff == OMAX && oy_ff == OMAX
                && oz_ff == OMAX) state_in = S_WRITE;
            if (nx_ok && ny_ok && nz_ok) own_in = 1'b0;
            if ((nx_ok && ny_ok && nz_ok) && ox_ff == OMAX && oy_ff == OMAX
                && oz_ff == OMAX) oob_in = 1'b1; // marks last neighbour
         end
         S_READ: begin
            re = 1'b1;
            du_clr = 1'b1;
            ax_in = 2'd0;
            state_in = S_DIST;
         end
         S_DIST: begin
            if (own_ff) begin
               if (rd_ff[ENTRY_W-1]) begin
                  st_in = ST_TOO_CLOSE; state_in = S_WRITE;
               end else begin
                  state_in = S_ADDR;
               end
               own_in = 1'b0;
            end else if (ax_ff == 2'd3) begin
               if (rd_ff[ENTRY_W-1] && du_acc < cfg.min_dist_sq) begin
                  st_in = ST_TOO_CLOSE; state_in = S_WRITE;
               end else if (oob_ff) begin
                  state_in = S_WRITE;
               end else begin
                  state_in = S_ADDR;
               end
            end else begin
               du_en = 1'b1;
               ax_in = ax_ff + 2'd1;
            end
         end
         S_WRITE: begin
            if (st_ff == ST_ACCEPTED) begin
               we = 1'b1; waddr = own_addr;
               wdata = {1'b1, cz_ff, cy_ff, cx_ff};
               pidx_in = cnt_ff[IDX_W-1:0];
               cnt_next = cnt_ff + CNT_W'(1);
               cnt_in = cnt_next;
            end
            done_in = (cnt_next >= cfg.target_count);
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         cnt_ff <= cnt_in;
      end
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      gx_ff <= gx_in; gy_ff <= gy_in; gz_ff <= gz_in;
      ox_ff <= ox_in; oy_ff <= oy_in; oz_ff <= oz_in;
      ax_ff <= ax_in; own_ff <= own_in; oob_ff <= oob_in;
      st_ff <= st_in; pidx_ff <= pidx_in; done_ff <= done_in;
      raddr_ff <= raddr_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {1'b0, done_ff, pidx_ff, st_ff};

   // checks
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != $past(cnt_ff) |-> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("accepted count jumped");
   a_idx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && st_ff != ST_ACCEPTED |-> pidx_ff == '0)
      else $error("index on rejected point");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("ready while result pending");

endmodule
`default_nettype wire

// ===== sim/poisson_disk_candidate_check_tb.sv =====
`timescale 1ns / 1ps
module poisson_disk_candidate_check_tb;
   import pdcc_pkg::*;

   localparam int GX = 16;
   localparam int GY = 16;
   localparam int GZ = 16;
   localparam int RADIUS = 2;
   localparam int CELL_COUNT = GX * GY * GZ;

   typedef struct {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
   } point_type;

   typedef struct {
      status_type  status;
      logic [11:0] index;
      logic        done;
   } verdict_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [5:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   poisson_disk_candidate_check dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // mirror of the grid and settings
   bit          grid_used [CELL_COUNT];
   point_type   grid_pt [CELL_COUNT];
   logic [12:0] stored_count;
   logic [35:0] m_min_dist;
   logic [23:0] m_inv_cell;
   logic [15:0] m_lower_x, m_lower_y, m_lower_z;
   logic [12:0] m_target;

   point_type   pending_requests[$];
   verdict_type expected_verdicts[$];
   int       error_count = 0;
   int       sent_count = 0;
   int       sender_idle_pct = 0;
   int       receiver_stall_pct = 0;
   bit       hold_off = 0;

   // clock and reset
   initial clock = 0;
   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   initial begin
      reset = 1;
      repeat (10) @(posedge clock);
      reset <= 0;
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic int axis_cell(logic [15:0] c, logic [15:0] lo, int grid);
      logic [63:0] prod;
      if (c < lo) return -1;
      prod = (64'(c - lo) * 64'(m_inv_cell)) >> 24;
      if (prod >= 64'(grid)) return -1;
      return int'(prod);
   endfunction

   function automatic logic [63:0] sq_gap(logic [15:0] a, logic [15:0] b);
      logic [63:0] d;
      d = (a >= b) ? 64'(a - b) : 64'(b - a);
      return d * d;
   endfunction

   // grid rejection test for one candidate, updates the mirrored grid
   task automatic judge_candidate(point_type p);
      verdict_type v;
      int          cx, cy, cz, nx, ny, nz, own, a;
      logic [63:0] d2;
      v.status = ST_ACCEPTED;
      v.index = '0;
      if (stored_count >= m_target) begin
         v.status = ST_TARGET;
      end else begin
         cx = axis_cell(p.x, m_lower_x, GX);
         cy = axis_cell(p.y, m_lower_y, GY);
         cz = axis_cell(p.z, m_lower_z, GZ);
         if (cx < 0 || cy < 0 || cz < 0) begin
            v.status = ST_OUTSIDE;
         end else begin
            own = (cz * GY + cy) * GX + cx;
            if (grid_used[own]) v.status = ST_TOO_CLOSE;
            for (int dz = -RADIUS; dz <= RADIUS && v.status == ST_ACCEPTED; dz++) begin
               nz = cz + dz;
               if (nz < 0 || nz >= GZ) continue;
               for (int dy = -RADIUS; dy <= RADIUS && v.status == ST_ACCEPTED; dy++) begin
                  ny = cy + dy;
                  if (ny < 0 || ny >= GY) continue;
                  for (int dx = -RADIUS; dx <= RADIUS; dx++) begin
                     nx = cx + dx;
                     if (nx < 0 || nx >= GX) continue;
                     a = (nz * GY + ny) * GX + nx;
                     if (!grid_used[a]) continue;
                     d2 = sq_gap(grid_pt[a].x, p.x) + sq_gap(grid_pt[a].y, p.y)
                        + sq_gap(grid_pt[a].z, p.z);
                     if (d2 < 64'(m_min_dist)) begin
                        v.status = ST_TOO_CLOSE;
                        break;
                     end
                  end
               end
            end
            if (v.status == ST_ACCEPTED) begin
               grid_used[own] = 1;
               grid_pt[own] = p;
               v.index = stored_count[11:0];
               stored_count = stored_count + 13'd1;
            end
         end
      end
      v.done = (stored_count >= m_target);
      expected_verdicts = {expected_verdicts, v};
   endtask

   // request driver
   always @(posedge clock) begin
      bit        fire;
      point_type p;
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= '0;
      end else begin
         fire = req_tvalid && req_tready;
         if (fire) begin
            p.x = req_tdata[15:0];
            p.y = req_tdata[31:16];
            p.z = req_tdata[47:32];
            judge_candidate(p);
            void'(pending_requests.pop_front());
            sent_count++;
         end
         if (!req_tvalid || fire) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_tvalid <= 1;
               req_tdata <= {pending_requests[0].z, pending_requests[0].y,
                             pending_requests[0].x};
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      verdict_type v;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("unexpected result", rsp_tdata, -1);
            end else begin
               v = expected_verdicts.pop_front();
               if (rsp_tdata[1:0] != v.status)
                  report_mismatch("status", rsp_tdata[1:0], v.status);
               if (rsp_tdata[13:2] != v.index)
                  report_mismatch("point_index", rsp_tdata[13:2], v.index);
               if (rsp_tdata[14] != v.done)
                  report_mismatch("done_res", rsp_tdata[14], v.done);
            end
         end
         rsp_tready <= !hold_off && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // long receiver hold-off so the block backs up its request side
   initial begin
      wait (sent_count >= 100);
      hold_off = 1;
      repeat (3000) @(posedge clock);
      hold_off = 0;
   end

   task automatic csr_write(logic [2:0] idx, logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic configure(logic [35:0] min_dist, logic [23:0] inv, logic [15:0] lx,
                            logic [15:0] ly, logic [15:0] lz, logic [12:0] target);
      csr_write(REG_MIN_DIST, 64'(min_dist));
      csr_write(REG_INV_CELL, 64'(inv));
      csr_write(REG_LOWER_X, 64'(lx));
      csr_write(REG_LOWER_Y, 64'(ly));
      csr_write(REG_LOWER_Z, 64'(lz));
      csr_write(REG_TARGET, 64'(target));
      m_min_dist = min_dist;
      m_inv_cell = inv;
      m_lower_x = lx;
      m_lower_y = ly;
      m_lower_z = lz;
      m_target = target;
   endtask

   task automatic drain;
      wait (pending_requests.size() == 0 && expected_verdicts.size() == 0 && !req_tvalid);
      repeat (32) @(posedge clock);
   endtask

   task automatic queue_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      point_type p;
      p.x = x;
      p.y = y;
      p.z = z;
      pending_requests = {pending_requests, p};
   endtask

   // mostly points inside the mapped grid, some anywhere
   function automatic logic [15:0] pick_coord(logic [15:0] lo);
      longint span;
      if ($urandom_range(99) < 15) return 16'($urandom);
      span = (m_inv_cell == 0) ? 65535 : ((longint'(16) << 24) / m_inv_cell);
      if (span > 65535) span = 65535;
      return 16'(lo + $urandom_range(0, int'(span)));
   endfunction

   task automatic random_phase(int n, int idle, int stall);
      sender_idle_pct = idle;
      receiver_stall_pct = stall;
      repeat (n) queue_point(pick_coord(m_lower_x), pick_coord(m_lower_y),
                             pick_coord(m_lower_z));
      drain();
   endtask

   // stimulus
   initial begin
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      stored_count = '0;
      m_min_dist = '0;
      m_inv_cell = 24'd65536;
      m_lower_x = '0;
      m_lower_y = '0;
      m_lower_z = '0;
      m_target = 13'd4096;
      wait (!reset);

      // reset settings: only an occupied own cell or a point outside the grid rejects
      queue_point(16'h0000, 16'h0000, 16'h0000);
      queue_point(16'h0000, 16'h0000, 16'h0000);
      queue_point(16'h0FFF, 16'h0FFF, 16'h0FFF);
      queue_point(16'h1000, 16'h0000, 16'h0000);
      queue_point(16'h0000, 16'h1000, 16'h0000);
      queue_point(16'h0000, 16'h0000, 16'h1000);
      queue_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_point(16'h0100, 16'h0000, 16'h0000);
      drain();

      // target reached, then target lowered under the count
      configure(36'd0, 24'd65536, 16'h0000, 16'h0000, 16'h0000, 13'd3);
      queue_point(16'h0200, 16'h0000, 16'h0000);
      drain();
      configure(36'd0, 24'd65536, 16'h0000, 16'h0000, 16'h0000, 13'd0);
      queue_point(16'h0300, 16'h0300, 16'h0300);
      drain();

      // neighbour closer than the minimum distance, and below the lower bound
      configure(36'd262144, 24'd65536, 16'h0000, 16'h0000, 16'h0000, 13'd4096);
      queue_point(16'h0280, 16'h0080, 16'h0000);
      queue_point(16'h0800, 16'h0800, 16'h0800);
      queue_point(16'h0900, 16'h0800, 16'h0800);
      drain();
      configure(36'd0, 24'd65536, 16'h0800, 16'h0001, 16'h0001, 13'd4096);
      queue_point(16'h0100, 16'h0100, 16'h0100);
      queue_point(16'h0900, 16'h0000, 16'h0100);
      queue_point(16'h0900, 16'h0100, 16'h0000);
      drain();

      // random phases through several settings and idling patterns
      configure(36'd196608, 24'd65536, 16'h0000, 16'h0000, 16'h0000, 13'd4096);
      random_phase(300, 0, 0);
      configure(36'd262144, 24'h020000, 16'h0100, 16'h0100, 16'h0100, 13'd4096);
      random_phase(300, 63, 0);
      configure(36'h000000100, 24'hFFFFFF, 16'h8000, 16'h4000, 16'hC000, 13'd4096);
      random_phase(250, 0, 63);
      configure(36'hFFFFFFFFF, 24'd0, 16'h1234, 16'h0000, 16'hFFF0, 13'd4096);
      random_phase(150, 18, 18);
      configure(36'd0, 24'h008000, 16'h0000, 16'h0000, 16'h0000, stored_count + 13'd20);
      random_phase(300, 18, 18);
      configure(36'd0, 24'd65536, 16'h0000, 16'h0000, 16'h0000, 13'd4096);
      random_phase(400, 0, 63);

      repeat (600) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #200_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
